/* rtl/core/mfba_pkg.sv */
// shared constants, register indexes and controller/datapath interface types
`default_nettype none
package mfba_pkg;

    localparam int MAX_NODES_DEF = 256;
    localparam int MAX_EDGES_DEF = 1024;
    localparam int CAP_BITS_DEF  = 32;

    localparam int NODE_W  = 8;
    localparam int CAPIN_W = 32;
    localparam int FLOW_W  = 42;
    localparam int NCNT_W  = 9;
    localparam int CFGI_W  = 2;
    localparam int CFGD_W  = 9;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 48;

    localparam logic [CFGI_W-1:0] REG_NODE_COUNT  = 2'd0;
    localparam logic [CFGI_W-1:0] REG_SOURCE_NODE = 2'd1;
    localparam logic [CFGI_W-1:0] REG_SINK_NODE   = 2'd2;

    typedef struct packed {
        logic clr_first;
        logic take_item;
        logic store_fwd;
        logic store_rev;
        logic solve_init;
        logic seen_clr;
        logic seed;
        logic deq_rd;
        logic node_rd;
        logic list_head;
        logic edge_rd;
        logic edge_chk;
        logic seen_chk;
        logic bn_init;
        logic aug_init;
        logic par_rd;
        logic par_take;
        logic bn_min;
        logic aug_sub;
        logic aug_add;
        logic flow_add;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic sclr_done;
        logic store_ok;
        logic last;
        logic st_ok;
        logic found;
        logic q_more;
        logic e_end;
        logic edge_qual;
        logic y_is_s;
        logic out_free;
    } dp_sts_t;

endpackage
`default_nettype wire

/* rtl/core/mfba_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module mfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/mfba_ctrl.sv */
// sequencer for edge loading, breadth-first search, bottleneck and augmentation
`default_nettype none
module mfba_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mfba_pkg::dp_sts_t sts,
    output mfba_pkg::dp_cmd_t      cmd
);
    import mfba_pkg::*;

    typedef enum logic [20:0] {
        ST_CLEAR = 21'h000001,
        ST_IDLE  = 21'h000002,
        ST_LOAD1 = 21'h000004,
        ST_LOAD2 = 21'h000008,
        ST_START = 21'h000010,
        ST_SCLR  = 21'h000020,
        ST_SEED  = 21'h000040,
        ST_DEQ   = 21'h000080,
        ST_DEQW  = 21'h000100,
        ST_FW    = 21'h000200,
        ST_EDGE  = 21'h000400,
        ST_EW    = 21'h000800,
        ST_SW    = 21'h001000,
        ST_BN    = 21'h002000,
        ST_BNP   = 21'h004000,
        ST_BNC   = 21'h008000,
        ST_AUG   = 21'h010000,
        ST_AUP   = 21'h020000,
        ST_AUC   = 21'h040000,
        ST_AUR   = 21'h080000,
        ST_DONE  = 21'h100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_first = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_LOAD1;
                end
            end
            ST_LOAD1:
            begin
                if (sts.store_ok)
                begin
                    cmd.store_fwd = 1'b1;
                    state_next    = ST_LOAD2;
                end
                else
                begin
                    state_next = sts.last ? ST_START : ST_IDLE;
                end
            end
            ST_LOAD2:
            begin
                cmd.store_rev = 1'b1;
                state_next    = sts.last ? ST_START : ST_IDLE;
            end
            ST_START:
            begin
                cmd.solve_init = 1'b1;
                state_next     = sts.st_ok ? ST_SCLR : ST_DONE;
            end
            ST_SCLR:
            begin
                cmd.seen_clr = 1'b1;
                if (sts.sclr_done)
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = ST_DEQ;
            end
            ST_DEQ:
            begin
                if (sts.found)
                begin
                    cmd.bn_init = 1'b1;
                    state_next  = ST_BN;
                end
                else if (sts.q_more)
                begin
                    cmd.deq_rd = 1'b1;
                    state_next = ST_DEQW;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DEQW:
            begin
                cmd.node_rd = 1'b1;
                state_next  = ST_FW;
            end
            ST_FW:
            begin
                cmd.list_head = 1'b1;
                state_next    = ST_EDGE;
            end
            ST_EDGE:
            begin
                if (sts.e_end)
                begin
                    state_next = ST_DEQ;
                end
                else
                begin
                    cmd.edge_rd = 1'b1;
                    state_next  = ST_EW;
                end
            end
            ST_EW:
            begin
                cmd.edge_chk = 1'b1;
                state_next   = sts.edge_qual ? ST_SW : ST_EDGE;
            end
            ST_SW:
            begin
                cmd.seen_chk = 1'b1;
                state_next   = ST_EDGE;
            end
            ST_BN:
            begin
                if (sts.y_is_s)
                begin
                    cmd.aug_init = 1'b1;
                    state_next   = ST_AUG;
                end
                else
                begin
                    cmd.par_rd = 1'b1;
                    state_next = ST_BNP;
                end
            end
            ST_BNP:
            begin
                cmd.par_take = 1'b1;
                state_next   = ST_BNC;
            end
            ST_BNC:
            begin
                cmd.bn_min = 1'b1;
                state_next = ST_BN;
            end
            ST_AUG:
            begin
                if (sts.y_is_s)
                begin
                    cmd.flow_add = 1'b1;
                    state_next   = ST_SCLR;
                end
                else
                begin
                    cmd.par_rd = 1'b1;
                    state_next = ST_AUP;
                end
            end
            ST_AUP:
            begin
                cmd.par_take = 1'b1;
                state_next   = ST_AUC;
            end
            ST_AUC:
            begin
                cmd.aug_sub = 1'b1;
                state_next  = ST_AUR;
            end
            ST_AUR:
            begin
                cmd.aug_add = 1'b1;
                state_next  = ST_AUG;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/mfba_dp.sv */
// datapath: residual edge tables, search scratch, counters, config and result registers
`default_nettype none
module mfba_dp #(
    parameter int MAX_NODES = mfba_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = mfba_pkg::MAX_EDGES_DEF,
    parameter int CAP_BITS  = mfba_pkg::CAP_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mfba_pkg::dp_cmd_t             cmd,
    output mfba_pkg::dp_sts_t                  sts,
    input  wire logic [mfba_pkg::NODE_W-1:0]   in_from,
    input  wire logic [mfba_pkg::NODE_W-1:0]   in_to,
    input  wire logic [mfba_pkg::CAPIN_W-1:0]  in_cap,
    input  wire logic                          in_last,
    input  wire logic                          cfg_we,
    input  wire logic [mfba_pkg::CFGI_W-1:0]   cfg_idx,
    input  wire logic [mfba_pkg::CFGD_W-1:0]   cfg_val,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [mfba_pkg::FLOW_W-1:0]   out_flow,
    output logic                               out_drop
);
    import mfba_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int NCW   = NW + 1;
    localparam int SW    = $clog2(2 * MAX_EDGES);
    localparam int EW    = $clog2(MAX_EDGES + 1);
    localparam int EDW   = NW + SW + 1;
    localparam int PARW  = 1 + NW + SW;

    // configuration
    logic [NCNT_W-1:0] ncount_reg;
    logic [NODE_W-1:0] src_reg, snk_reg;

    // control state
    logic [NW-1:0]  idx_reg, idx_next;
    logic [EW-1:0]  count_reg, count_next;
    logic           ovf_reg, ovf_next;
    logic [NW:0]    head_reg, head_next, tail_reg, tail_next;
    logic           found_reg, found_next;
    logic           ok_reg, ok_next, last_reg, last_next;
    logic           oval_reg, oval_next;

    // payload
    logic [NW-1:0]       u_reg, v_reg, x_reg, y_reg, p_reg;
    logic [CAP_BITS-1:0] capin_reg, bottle_reg;
    logic [SW:0]         e_reg, nxt_reg;
    logic [FLOW_W-1:0]   flow_reg, oflow_reg;
    logic                odrop_reg;

    // memories
    logic                first_we, edge_we, cap_we, par_we, q_we;
    logic [NW-1:0]       first_wa, first_ra, par_wa, par_ra, q_wa, q_ra;
    logic [SW:0]         first_wd, first_rd;
    logic [SW-1:0]       edge_wa, cap_wa, cap_ra;
    logic [EDW-1:0]      edge_wd, edge_rd;
    logic [CAP_BITS-1:0] cap_wd, cap_rd;
    logic [PARW-1:0]     par_wd, par_rd;
    logic [NW-1:0]       q_wd, q_rd;

    logic [NCW-1:0]      n_w;
    logic [NW-1:0]       s_n, t_n;
    logic [SW-1:0]       f_w, e_tw;
    logic [NW-1:0]       er_tgt, pr_node;
    logic [SW:0]         er_nxt;
    logic [SW-1:0]       pr_edge;
    logic                pr_seen, ends_ok, qual;

    assign n_w = (32'(ncount_reg) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(ncount_reg);
    assign s_n = NW'(src_reg);
    assign t_n = NW'(snk_reg);
    assign f_w = SW'({count_reg, 1'b0});
    assign e_tw = e_reg[SW-1:0] ^ SW'(1);

    assign er_tgt  = edge_rd[EDW-1 -: NW];
    assign er_nxt  = edge_rd[SW:0];
    assign pr_seen = par_rd[PARW-1];
    assign pr_node = par_rd[PARW-2 -: NW];
    assign pr_edge = par_rd[SW-1:0];

    assign ends_ok = (32'(in_from) < MAX_NODES) && (32'(in_to) < MAX_NODES);
    assign qual    = (cap_rd != '0) && (NCW'(er_tgt) < n_w);

    always_comb
    begin
        sts.clr_done  = (idx_reg == NW'(MAX_NODES - 1));
        sts.sclr_done = ((NCW'(idx_reg) + NCW'(1)) == n_w);
        sts.store_ok  = ok_reg;
        sts.last      = last_reg;
        sts.st_ok     = (32'(src_reg) < 32'(n_w)) && (32'(snk_reg) < 32'(n_w))
                        && (src_reg != snk_reg);
        sts.found     = found_reg;
        sts.q_more    = (head_reg < tail_reg);
        sts.e_end     = e_reg[SW];
        sts.edge_qual = qual;
        sts.y_is_s    = (y_reg == s_n);
        sts.out_free  = !oval_reg || out_ready;
    end

    // memory port steering
    always_comb
    begin
        first_we = cmd.clr_first || cmd.store_fwd || cmd.store_rev;
        first_wa = cmd.clr_first ? idx_reg : (cmd.store_fwd ? u_reg : v_reg);
        first_wd = cmd.clr_first ? {1'b1, SW'(0)}
                 : (cmd.store_fwd ? {1'b0, f_w} : {1'b0, f_w ^ SW'(1)});
        first_ra = cmd.take_item ? NW'(in_from) : (cmd.store_fwd ? v_reg : q_rd);

        edge_we = cmd.store_fwd || cmd.store_rev;
        edge_wa = cmd.store_fwd ? f_w : (f_w ^ SW'(1));
        if (cmd.store_fwd)
        begin
            edge_wd = {v_reg, first_rd};
        end
        else
        begin
            // self loop: the forward slot was just linked ahead of the reverse slot
            edge_wd = {u_reg, (u_reg == v_reg) ? {1'b0, f_w} : first_rd};
        end

        cap_we = cmd.store_fwd || cmd.store_rev || cmd.aug_sub || cmd.aug_add;
        if (cmd.store_fwd)
        begin
            cap_wa = f_w;
            cap_wd = capin_reg;
        end
        else if (cmd.store_rev)
        begin
            cap_wa = f_w ^ SW'(1);
            cap_wd = '0;
        end
        else if (cmd.aug_sub)
        begin
            cap_wa = e_reg[SW-1:0];
            cap_wd = cap_rd - bottle_reg;
        end
        else
        begin
            cap_wa = e_tw;
            cap_wd = cap_rd + bottle_reg;
        end
        cap_ra = cmd.par_take ? pr_edge : (cmd.aug_sub ? e_tw : e_reg[SW-1:0]);

        par_we = cmd.seen_clr || cmd.seed || (cmd.seen_chk && !pr_seen);
        par_wa = cmd.seen_clr ? idx_reg : (cmd.seed ? s_n : y_reg);
        par_wd = cmd.seen_clr ? '0 : {1'b1, x_reg, e_reg[SW-1:0]};
        par_ra = cmd.edge_chk ? er_tgt : y_reg;

        q_we = cmd.seed || (cmd.seen_chk && !pr_seen && (32'(tail_reg) < MAX_NODES));
        q_wa = cmd.seed ? '0 : tail_reg[NW-1:0];
        q_wd = cmd.seed ? s_n : y_reg;
        q_ra = head_reg[NW-1:0];
    end

    mfba_ram #(.WIDTH(SW + 1), .DEPTH(MAX_NODES)) u_first (
        .clk(clk), .we(first_we), .waddr(first_wa), .wdata(first_wd),
        .raddr(first_ra), .rdata(first_rd)
    );

    mfba_ram #(.WIDTH(EDW), .DEPTH(2 * MAX_EDGES)) u_edge (
        .clk(clk), .we(edge_we), .waddr(edge_wa), .wdata(edge_wd),
        .raddr(e_reg[SW-1:0]), .rdata(edge_rd)
    );

    mfba_ram #(.WIDTH(CAP_BITS), .DEPTH(2 * MAX_EDGES)) u_cap (
        .clk(clk), .we(cap_we), .waddr(cap_wa), .wdata(cap_wd),
        .raddr(cap_ra), .rdata(cap_rd)
    );

    mfba_ram #(.WIDTH(PARW), .DEPTH(MAX_NODES)) u_par (
        .clk(clk), .we(par_we), .waddr(par_wa), .wdata(par_wd),
        .raddr(par_ra), .rdata(par_rd)
    );

    mfba_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd),
        .raddr(q_ra), .rdata(q_rd)
    );

    // control next state
    always_comb
    begin
        idx_next   = (cmd.clr_first || cmd.seen_clr) ? idx_reg + NW'(1) : '0;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        found_next = found_reg;
        ok_next    = ok_reg;
        last_next  = last_reg;
        oval_next  = (oval_reg && !out_ready) || cmd.emit;
        if (cmd.clr_first)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        if (cmd.take_item)
        begin
            ok_next   = ends_ok && (32'(count_reg) < MAX_EDGES);
            last_next = in_last;
            if (ends_ok && !(32'(count_reg) < MAX_EDGES))
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.store_rev)
        begin
            count_next = count_reg + EW'(1);
        end
        if (cmd.seed)
        begin
            head_next  = '0;
            tail_next  = (NW + 1)'(1);
            found_next = 1'b0;
        end
        if (cmd.deq_rd)
        begin
            head_next = head_reg + (NW + 1)'(1);
        end
        if (cmd.seen_chk && !pr_seen)
        begin
            if (32'(tail_reg) < MAX_NODES)
            begin
                tail_next = tail_reg + (NW + 1)'(1);
            end
            if (y_reg == t_n)
            begin
                found_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncount_reg <= NCNT_W'(2);
            src_reg    <= '0;
            snk_reg    <= NODE_W'(1);
            idx_reg    <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            head_reg   <= '0;
            tail_reg   <= '0;
            found_reg  <= 1'b0;
            ok_reg     <= 1'b0;
            last_reg   <= 1'b0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_NODE_COUNT:  ncount_reg <= cfg_val;
                    REG_SOURCE_NODE: src_reg    <= cfg_val[NODE_W-1:0];
                    REG_SINK_NODE:   snk_reg    <= cfg_val[NODE_W-1:0];
                    default:         ncount_reg <= ncount_reg;
                endcase
            end
            idx_reg   <= idx_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            found_reg <= found_next;
            ok_reg    <= ok_next;
            last_reg  <= last_next;
            oval_reg  <= oval_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            u_reg     <= NW'(in_from);
            v_reg     <= NW'(in_to);
            capin_reg <= CAP_BITS'(in_cap);
        end
        if (cmd.node_rd)
        begin
            x_reg <= q_rd;
        end
        if (cmd.list_head)
        begin
            e_reg <= first_rd;
        end
        if (cmd.edge_chk)
        begin
            y_reg   <= er_tgt;
            nxt_reg <= er_nxt;
            if (!qual)
            begin
                e_reg <= er_nxt;
            end
        end
        if (cmd.seen_chk)
        begin
            e_reg <= nxt_reg;
        end
        if (cmd.bn_init)
        begin
            y_reg      <= t_n;
            bottle_reg <= '1;
        end
        if (cmd.aug_init)
        begin
            y_reg <= t_n;
        end
        if (cmd.par_take)
        begin
            p_reg <= pr_node;
            e_reg <= {1'b0, pr_edge};
        end
        if (cmd.bn_min)
        begin
            if (cap_rd < bottle_reg)
            begin
                bottle_reg <= cap_rd;
            end
            y_reg <= p_reg;
        end
        if (cmd.aug_add)
        begin
            y_reg <= p_reg;
        end
        if (cmd.solve_init)
        begin
            flow_reg <= '0;
        end
        if (cmd.flow_add)
        begin
            flow_reg <= flow_reg + FLOW_W'(bottle_reg);
        end
        if (cmd.emit)
        begin
            oflow_reg <= sts.st_ok ? flow_reg : '0;
            odrop_reg <= ovf_reg;
        end
    end

    assign out_valid = oval_reg;
    assign out_flow  = oflow_reg;
    assign out_drop  = odrop_reg;

endmodule
`default_nettype wire

/* rtl/core/max_flow_bfs_augment.sv */
// max_flow_bfs_augment: edge loader and breadth-first max-flow solver
// each edge is taken, then stored in its forward and reverse slots unless it is dropped; after the last
//   edge the solver repeats searches, each clearing the seen scratch and dequeuing nodes to scan their
//   edges, then walking the path back for the bottleneck and again for augmentation; it then emits
// one graph is solved at a time; edges of the next graph are taken only after the result is emitted
// reset: after reset and after each result, all MAX_NODES adjacency list heads are cleared
//   while no edge is taken; configuration writes are taken at any time
`default_nettype none
module max_flow_bfs_augment #(
    parameter int MAX_NODES = mfba_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = mfba_pkg::MAX_EDGES_DEF,
    parameter int CAP_BITS  = mfba_pkg::CAP_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // from_node [7:0], to_node [15:8], capacity [47:16]
    input  wire logic [mfba_pkg::IN_W-1:0]     s_axis_tdata,
    input  wire logic                          s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // total flow [41:0], zero [47:42]
    output logic      [mfba_pkg::OUT_W-1:0]    m_axis_tdata,
    // edges_dropped [0]
    output logic                               m_axis_tuser,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mfba_pkg::CFGI_W-1:0]   cfg_index,
    input  wire logic [mfba_pkg::CFGD_W-1:0]   cfg_data
);
    import mfba_pkg::*;

    dp_cmd_t           cmd;
    dp_sts_t           sts;
    logic [FLOW_W-1:0] flow_w;

    assign cfg_ready = 1'b1;

    mfba_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .sts(sts), .cmd(cmd)
    );

    mfba_dp #(
        .MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES), .CAP_BITS(CAP_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_from(s_axis_tdata[7:0]),
        .in_to(s_axis_tdata[15:8]),
        .in_cap(s_axis_tdata[47:16]),
        .in_last(s_axis_tlast),
        .cfg_we(cfg_valid && cfg_ready),
        .cfg_idx(cfg_index), .cfg_val(cfg_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_flow(flow_w), .out_drop(m_axis_tuser)
    );

    assign m_axis_tdata = {(OUT_W - FLOW_W)'(0), flow_w};

    a_cap_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.store_fwd, cmd.store_rev, cmd.aug_sub, cmd.aug_add}))
        else $error("more than one residual capacity write in a cycle");

    a_rev_after_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_rev |-> $past(cmd.store_fwd))
        else $error("reverse slot stored without its forward slot");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.emit))
        else $error("result raised without a finished solve");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result transaction changed");

endmodule
`default_nettype wire

/* sim/max_flow_bfs_augment_tb.sv */
// testbench for max_flow_bfs_augment: directed and random graphs checked against a max-flow predictor
`timescale 1ns / 100ps
`default_nettype none
module max_flow_bfs_augment_tb;
    import mfba_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SLOTS = 2048;
    localparam int EDGE_SLOTS = 1024;

    typedef struct {
        logic [41:0] flow;
        logic        dropped;
    } flow_result_t;

    class flow_scoreboard;
        logic [7:0]  target_node[SLOTS];
        logic [31:0] resid[SLOTS];
        int          next_slot[SLOTS];
        int          list_head[256];
        int          edge_total;
        bit          table_full;
        int          node_limit;
        int          src;
        int          snk;
        flow_result_t awaited[$];
        int          errors;

        function new();
            node_limit = 2;
            src = 0;
            snk = 1;
            errors = 0;
            clear_graph();
        endfunction

        function void clear_graph();
            foreach (list_head[i]) list_head[i] = SLOTS;
            edge_total = 0;
            table_full = 0;
        endfunction

        function void note_config(logic [CFGI_W-1:0] idx, logic [CFGD_W-1:0] val);
            if (idx == REG_NODE_COUNT) node_limit = val;
            else if (idx == REG_SOURCE_NODE) src = val[7:0];
            else if (idx == REG_SINK_NODE) snk = val[7:0];
        endfunction

        function logic [41:0] augment_all();
            int n;
            int qhead;
            int qtail;
            int x;
            int y;
            int e;
            bit seen[256];
            int parent_node[256];
            int parent_slot[256];
            int fifo[256];
            logic [31:0] bottle;
            logic [41:0] total;
            total = '0;
            n = node_limit > 256 ? 256 : node_limit;
            if (src >= n || snk >= n || src == snk) return total;
            forever
            begin
                foreach (seen[i]) seen[i] = 0;
                qhead = 0;
                qtail = 1;
                fifo[0] = src;
                seen[src] = 1;
                while (qhead < qtail && !seen[snk])
                begin
                    x = fifo[qhead];
                    qhead++;
                    for (e = list_head[x]; e < SLOTS; e = next_slot[e])
                    begin
                        y = target_node[e];
                        if (resid[e] != 0 && y < n && !seen[y])
                        begin
                            seen[y] = 1;
                            parent_node[y] = x;
                            parent_slot[y] = e;
                            fifo[qtail] = y;
                            qtail++;
                        end
                    end
                end
                if (!seen[snk]) break;
                bottle = '1;
                for (y = snk; y != src; y = parent_node[y])
                    if (resid[parent_slot[y]] < bottle) bottle = resid[parent_slot[y]];
                for (y = snk; y != src; y = parent_node[y])
                begin
                    resid[parent_slot[y]] -= bottle;
                    resid[parent_slot[y] ^ 1] += bottle;
                end
                total += bottle;
            end
            return total;
        endfunction

        function void note_edge(logic [7:0] u, logic [7:0] v, logic [31:0] cap, logic last);
            int f;
            flow_result_t r;
            if (edge_total >= EDGE_SLOTS)
                table_full = 1;
            else
            begin
                f = 2 * edge_total;
                target_node[f] = v;
                resid[f] = cap;
                next_slot[f] = list_head[u];
                list_head[u] = f;
                target_node[f+1] = u;
                resid[f+1] = '0;
                next_slot[f+1] = list_head[v];
                list_head[v] = f + 1;
                edge_total++;
            end
            if (last)
            begin
                r.flow = augment_all();
                r.dropped = table_full;
                awaited.insert(awaited.size(), r);
                clear_graph();
            end
        endfunction

        function void check(logic [41:0] flow, logic dropped);
            flow_result_t r;
            if (awaited.size() == 0)
            begin
                $error("unexpected result transaction: total_flow %0d", flow);
                errors++;
                return;
            end
            r = awaited.pop_front();
            if (flow !== r.flow)
            begin
                $error("total_flow: expected %0d, actual %0d", r.flow, flow);
                errors++;
            end
            if (dropped !== r.dropped)
            begin
                $error("edges_dropped: expected %0d, actual %0d", r.dropped, dropped);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;
    logic               s_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               m_axis_tuser;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFGI_W-1:0]  cfg_index;
    logic [CFGD_W-1:0]  cfg_data;

    flow_scoreboard sb = new();
    int idle_mode = 0;
    int cycles = 0;
    int items_sent = 0;

    max_flow_bfs_augment u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // receiver stalls by phase
    always @(posedge clk)
    begin
        if (idle_mode == 2) m_axis_tready <= ($urandom_range(99) >= 88);
        else if (idle_mode == 3) m_axis_tready <= ($urandom_range(99) >= 16);
        else m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check(m_axis_tdata[FLOW_W-1:0], m_axis_tuser);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [CFGI_W-1:0] idx, logic [CFGD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.note_config(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_graph(int n, int s, int t);
        write_reg(REG_NODE_COUNT, CFGD_W'(n));
        write_reg(REG_SOURCE_NODE, CFGD_W'(s));
        write_reg(REG_SINK_NODE, CFGD_W'(t));
    endtask

    // leaves tvalid high between edges unless a random stall lowers it; the task lowers it itself after the last edge
    task automatic send_edge(logic [7:0] u, logic [7:0] v, logic [31:0] cap, logic last);
        int stall;
        stall = (idle_mode == 1) ? 88 : (idle_mode == 3) ? 16 : 0;
        if ($urandom_range(99) < stall)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < stall) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cap, v, u};
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_edge(u, v, cap, last);
        items_sent++;
        if (last) s_axis_tvalid <= 1'b0;
    endtask

    // waits out the result and the list-head clearing pass
    task automatic drain();
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_cap();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1, 20);
            2: return '1;
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    task automatic random_graph();
        int n;
        int s;
        int t;
        int edges;
        int pick;
        pick = $urandom_range(19);
        if (pick == 0) n = 256;
        else if (pick == 1) n = $urandom_range(257, 511);
        else if (pick == 2) n = 2;
        else n = $urandom_range(3, 8);
        s = $urandom_range(0, (n > 256 ? 255 : n - 1));
        t = $urandom_range(0, (n > 256 ? 255 : n - 1));
        if ($urandom_range(9) == 0) t = s;
        if ($urandom_range(19) == 0) s = $urandom_range(255);
        set_graph(n, s, t);
        edges = $urandom_range(1, 16);
        for (int i = 0; i < edges; i++)
        begin
            if (n > 8 || $urandom_range(19) == 0)
                send_edge(8'($urandom_range(255)), 8'($urandom_range(255)), rand_cap(),
                          i == edges - 1);
            else
                send_edge(8'($urandom_range(n - 1)), 8'($urandom_range(n - 1)), rand_cap(),
                          i == edges - 1);
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (300) @(posedge clk);

        // reset settings: single edge at full capacity
        send_edge(8'd0, 8'd1, 32'hffff_ffff, 1'b1);
        drain();
        // diamond with a cross edge, zero capacity and a self loop
        set_graph(4, 0, 3);
        send_edge(8'd0, 8'd1, 32'd10, 1'b0);
        send_edge(8'd0, 8'd2, 32'd5, 1'b0);
        send_edge(8'd1, 8'd2, 32'd15, 1'b0);
        send_edge(8'd1, 8'd3, 32'd5, 1'b0);
        send_edge(8'd2, 8'd3, 32'd10, 1'b0);
        send_edge(8'd2, 8'd2, 32'd7, 1'b0);
        send_edge(8'd0, 8'd3, 32'd0, 1'b1);
        drain();
        // source equals sink
        set_graph(4, 2, 2);
        send_edge(8'd2, 8'd3, 32'd9, 1'b1);
        drain();
        // sink outside node_count, endpoint outside node_count
        set_graph(3, 0, 5);
        send_edge(8'd0, 8'd5, 32'd9, 1'b1);
        drain();
        set_graph(3, 0, 1);
        send_edge(8'd0, 8'd200, 32'd9, 1'b0);
        send_edge(8'd200, 8'd1, 32'd9, 1'b1);
        drain();
        // largest nodes, flow summing past 32 bits
        set_graph(256, 255, 254);
        send_edge(8'd255, 8'd254, 32'hffff_ffff, 1'b0);
        send_edge(8'd255, 8'd254, 32'hffff_ffff, 1'b0);
        send_edge(8'd255, 8'd254, 32'hffff_fffe, 1'b1);
        drain();
        // full edge table: parallel loops on an unreached node, then dropped edges
        set_graph(4, 0, 1);
        send_edge(8'd0, 8'd1, 32'd77, 1'b0);
        for (int i = 0; i < EDGE_SLOTS + 4; i++)
            send_edge(8'd200, 8'd200, $urandom, i == EDGE_SLOTS + 3);
        drain();

        while (items_sent < 1400)
        begin
            idle_mode = (items_sent / 100) % 4;
            random_graph();
        end
        idle_mode = 0;
        drain();

        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
rtl/core/mfba_pkg.sv
rtl/core/mfba_ram.sv
rtl/core/mfba_ctrl.sv
rtl/core/mfba_dp.sv
rtl/core/max_flow_bfs_augment.sv
sim/max_flow_bfs_augment_tb.sv
